[hw/rtl/five_tuple_acl_packet_filter_core_macros.svh]
// Assertion macros for the five-tuple ACL filter core.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef FIVE_TUPLE_ACL_PACKET_FILTER_CORE_MACROS_SVH
`define FIVE_TUPLE_ACL_PACKET_FILTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define FTAF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ftaf assertion failed");
`define FTAF_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("ftaf reset assertion failed");
`else
`define FTAF_ASSERT(lbl, prop)
`define FTAF_ASSERT_RST(lbl, prop)
`endif
`endif

[hw/rtl/ftaf_pkg.sv]
// Shared types, codes and constants for the five-tuple ACL filter core.
// No dependencies.
package ftaf_pkg;

   localparam int ACL_DEPTH_DEF = 1024;

   localparam logic [1:0] CMD_BYTE   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   localparam logic [2:0] VERDICT_ABORTED  = 3'd0;
   localparam logic [2:0] VERDICT_DROP     = 3'd1;
   localparam logic [2:0] VERDICT_PASS     = 3'd2;
   localparam logic [2:0] VERDICT_TX       = 3'd3;
   localparam logic [2:0] VERDICT_REDIRECT = 3'd4;
   localparam logic [2:0] ACT_MAX          = 3'd4;

   localparam logic [1:0] WST_DONE      = 2'd0;
   localparam logic [1:0] WST_FULL      = 2'd1;
   localparam logic [1:0] WST_NOT_FOUND = 2'd2;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       lookup;
      logic [2:0] verdict;
   } parse_type;

   typedef struct packed {
      logic        pa_we;
      logic        addr_we;
      logic [63:0] addr;
      logic [43:0] pa;
   } acl_wr_type;

endpackage

[hw/rtl/five_tuple_acl_packet_filter_core.sv]
// Five-tuple exact-match ACL packet filter core, top level.
// Packet bytes do not hold the input; a frame needing a lookup and every rule transfer hold
// it through a linear scan of the ACL memory, and the result is registered in the finish
// state after the scan. The input stalls while a result waits.
// Reset (synchronous) clears control, then a clearing pass over every ACL entry
// empties the table before the first input transfer is accepted.
`include "five_tuple_acl_packet_filter_core_macros.svh"
module five_tuple_acl_packet_filter_core #(
   parameter int ACL_DEPTH = ftaf_pkg::ACL_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // packet_byte, rule_src_addr, rule_dst_addr, rule_src_port, rule_dst_port,
   // rule_proto, rule_action, zero pad
   input  logic [119:0] req_tdata,
   input  logic [1:0]   req_tuser,   // command
   input  logic         req_tlast,   // packet_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // verdict, rule_hit, write_status, zero pad
   output logic         rsp_tuser    // result_kind
);
   import ftaf_pkg::*;

   localparam int AW = $clog2(ACL_DEPTH);
   localparam logic [AW:0] DEPTH_CNT = (AW+1)'(ACL_DEPTH);

   state_type   state_ff, state_in;
   logic [AW:0] scan_ff, scan_in;
   logic        rd_pend_ff;
   logic [AW-1:0] rd_idx_ff;
   logic        match_ff, match_in, free_ff, free_in;
   logic [AW-1:0] match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [2:0]  match_act_ff, match_act_in;
   logic [1:0]  op_ff, op_in;
   logic [63:0] key_addr_ff, key_addr_in;
   logic [39:0] key_ports_ff, key_ports_in;
   logic [2:0]  key_act_ff, key_act_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_kind_ff, rsp_kind_in;

   logic        acc, slot_free, scan_done, rd_en, hit_now;
   parse_type   parse;
   logic [63:0] p_addr, rd_addr;
   logic [39:0] p_ports;
   logic [43:0] rd_pa;
   acl_wr_type  wr;
   logic [AW-1:0] wr_idx;
   logic [2:0]  fin_verdict;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign acc        = req_tvalid && req_tready;
   assign scan_done  = (scan_ff == DEPTH_CNT) && !rd_pend_ff;
   assign rd_en      = (state_ff == ST_SCAN) && (scan_ff != DEPTH_CNT);

   ftaf_hdr_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_strobe(acc && req_tuser == CMD_BYTE),
      .byte_data  (req_tdata[7:0]),
      .byte_last  (req_tlast),
      .parse      (parse),
      .key_addr   (p_addr),
      .key_ports  (p_ports)
   );

   ftaf_acl_mem #(.ACL_DEPTH(ACL_DEPTH), .AW(AW)) u_mem (
      .clock  (clock),
      .wr     (wr),
      .wr_idx (wr_idx),
      .rd_en  (rd_en),
      .rd_idx (scan_ff[AW-1:0]),
      .rd_addr(rd_addr),
      .rd_pa  (rd_pa)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_ff == DEPTH_CNT - 1'b1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (acc) begin
               unique case (req_tuser) inside
                  CMD_BYTE: begin
                     if (req_tlast && parse.lookup) state_in = ST_SCAN;
                  end
                  CMD_INSERT, CMD_DELETE: state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign hit_now = rd_pend_ff && rd_pa[43] && rd_pa[42:3] == key_ports_ff
                    && rd_addr == key_addr_ff;

   always_comb begin
      if (!match_ff) fin_verdict = VERDICT_TX;
      else if (match_act_ff > ACT_MAX) fin_verdict = VERDICT_ABORTED;
      else fin_verdict = match_act_ff;
   end

   // outputs and datapath
   always_comb begin
      scan_in      = scan_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_act_in = match_act_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      op_in        = op_ff;
      key_addr_in  = key_addr_ff;
      key_ports_in = key_ports_ff;
      key_act_in   = key_act_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      wr           = '0;
      wr_idx       = scan_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            wr.pa_we = 1'b1;
            scan_in  = scan_ff + 1'b1;
         end
         ST_IDLE: begin
            scan_in  = '0;
            match_in = 1'b0;
            free_in  = 1'b0;
            if (acc) begin
               op_in        = req_tuser;
               key_addr_in  = {req_tdata[39:8], req_tdata[71:40]};
               key_ports_in = {req_tdata[111:104], req_tdata[87:72], req_tdata[103:88]};
               key_act_in   = req_tdata[114:112];
               if (req_tuser == CMD_BYTE) begin
                  key_addr_in  = p_addr;
                  key_ports_in = p_ports;
                  if (req_tlast && !parse.lookup) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_VERDICT;
                     rsp_data_in  = {2'b00, WST_DONE, 1'b0, parse.verdict};
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) scan_in = scan_ff + 1'b1;
            if (hit_now && !match_ff) begin
               match_in     = 1'b1;
               match_idx_in = rd_idx_ff;
               match_act_in = rd_pa[2:0];
            end
            if (rd_pend_ff && !rd_pa[43] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_idx_ff;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               wr.addr      = key_addr_ff;
               wr.pa        = {1'b1, key_ports_ff, key_act_ff};
               wr_idx       = match_ff ? match_idx_ff : free_idx_ff;
               if (op_ff == CMD_BYTE) begin
                  rsp_kind_in = KIND_VERDICT;
                  rsp_data_in = {2'b00, WST_DONE, match_ff, fin_verdict};
               end else if (op_ff == CMD_INSERT) begin
                  rsp_kind_in = KIND_ACK;
                  wr.pa_we    = match_ff || free_ff;
                  wr.addr_we  = match_ff || free_ff;
                  rsp_data_in = {2'b00, (match_ff || free_ff) ? WST_DONE : WST_FULL,
                                 1'b0, VERDICT_ABORTED};
               end else begin
                  rsp_kind_in = KIND_ACK;
                  wr.pa_we    = match_ff;
                  wr.pa       = '0;
                  rsp_data_in = {2'b00, match_ff ? WST_DONE : WST_NOT_FOUND,
                                 1'b0, VERDICT_ABORTED};
               end
            end
         end
         default: wr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
      end
      rd_idx_ff    <= scan_ff[AW-1:0];
      match_idx_ff <= match_idx_in;
      match_act_ff <= match_act_in;
      free_idx_ff  <= free_idx_in;
      op_ff        <= op_in;
      key_addr_ff  <= key_addr_in;
      key_ports_ff <= key_ports_in;
      key_act_ff   <= key_act_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   `FTAF_ASSERT(a_finish_drained, state_ff == ST_FINISH |-> !rd_pend_ff)
   `FTAF_ASSERT_RST(a_no_accept_after_reset, reset |=> !req_tready)
   `FTAF_ASSERT(a_scan_no_accept, state_ff == ST_SCAN |-> !req_tready)

endmodule

[hw/rtl/ftaf_acl_mem.sv]
// ACL table storage: address store and port/action store, registered read.
// Depends on ftaf_pkg.
module ftaf_acl_mem #(
   parameter int ACL_DEPTH = ftaf_pkg::ACL_DEPTH_DEF,
   parameter int AW        = $clog2(ACL_DEPTH)
) (
   input  logic                   clock,
   input  ftaf_pkg::acl_wr_type   wr,
   input  logic [AW-1:0]          wr_idx,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_idx,
   output logic [63:0]            rd_addr,
   output logic [43:0]            rd_pa
);
   import ftaf_pkg::*;

   logic [63:0] addr_mem [ACL_DEPTH];
   logic [43:0] pa_mem   [ACL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.addr_we) begin
         addr_mem[wr_idx] <= wr.addr;
      end
      if (wr.pa_we) begin
         pa_mem[wr_idx] <= wr.pa;
      end
      if (rd_en) begin
         rd_addr <= addr_mem[rd_idx];
         rd_pa   <= pa_mem[rd_idx];
      end
   end

endmodule

[hw/rtl/ftaf_hdr_parse.sv]
// Frame header capture: byte counter, field capture on the fly, end-of-frame checks.
// Depends on ftaf_pkg.
module ftaf_hdr_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_strobe,
   input  logic [7:0]          byte_data,
   input  logic                byte_last,
   output ftaf_pkg::parse_type parse,
   output logic [63:0]         key_addr,
   output logic [39:0]         key_ports
);
   import ftaf_pkg::*;

   logic [15:0] count_ff, count_in, len;
   logic [15:0] eth_ff, eth_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in, dst_ff, dst_in;
   logic [15:0] sp_ff, sp_in, dp_ff, dp_in;
   logic [6:0]  t_off, t_end;
   logic [15:0] t_pos;

   always_comb begin
      eth_in   = eth_ff;
      ihl_in   = ihl_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      sp_in    = sp_ff;
      dp_in    = dp_ff;
      len      = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
      count_in = count_ff;
      if (byte_strobe) begin
         count_in = byte_last ? 16'd0 : len;
         if (count_ff == 16'd12) eth_in[15:8] = byte_data;
         if (count_ff == 16'd13) eth_in[7:0]  = byte_data;
         if (count_ff == 16'd14) ihl_in       = byte_data[3:0];
         if (count_ff == 16'd23) proto_in     = byte_data;
         for (int i = 0; i < 4; i++) begin
            if (count_ff == 16'(26 + i)) src_in[31-8*i -: 8] = byte_data;
            if (count_ff == 16'(30 + i)) dst_in[31-8*i -: 8] = byte_data;
         end
      end
      t_off = 7'd14 + {1'b0, ihl_in, 2'b00};
      t_pos = {9'd0, t_off};
      if (byte_strobe) begin
         if (count_ff == t_pos)          sp_in[15:8] = byte_data;
         if (count_ff == t_pos + 16'd1)  sp_in[7:0]  = byte_data;
         if (count_ff == t_pos + 16'd2)  dp_in[15:8] = byte_data;
         if (count_ff == t_pos + 16'd3)  dp_in[7:0]  = byte_data;
      end
      t_end = t_off + ((proto_in == PROTO_TCP) ? 7'd20 : 7'd8);
   end

   always_comb begin
      parse.lookup  = 1'b0;
      parse.verdict = VERDICT_TX;
      if (len < 16'd14) begin
         parse.verdict = VERDICT_ABORTED;
      end else if (eth_in != ETHERTYPE_IPV4) begin
         parse.verdict = VERDICT_TX;
      end else if (len < 16'd34) begin
         parse.verdict = VERDICT_ABORTED;
      end else if (proto_in != PROTO_TCP && proto_in != PROTO_UDP) begin
         parse.verdict = VERDICT_TX;
      end else if ({9'd0, t_end} > len) begin
         parse.verdict = VERDICT_ABORTED;
      end else begin
         parse.lookup = 1'b1;
      end
   end

   assign key_addr  = {src_in, dst_in};
   assign key_ports = {proto_in, sp_in, dp_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      eth_ff   <= eth_in;
      ihl_ff   <= ihl_in;
      proto_ff <= proto_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      sp_ff    <= sp_in;
      dp_ff    <= dp_in;
   end

endmodule
